// ===== rtl/core/hss_pkg.sv =====
// Package for the half-step stepper sequencer: payload structs, item kinds,
// reset constants and the eight-phase coil table. It depends on nothing.
`default_nettype none

package hss_pkg;

    // Kinds of input transaction.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Reset value of the step interval register.
    localparam logic [15:0] INTERVAL_RESET = 16'd80;

    // Input transaction payload.
    typedef struct packed {
        logic               kind;
        logic signed [15:0] step_count;
    } in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [3:0]         coils;
        logic               stepped;
        logic signed [31:0] position;
        logic signed [15:0] remaining;
    } out_t;

    // Half-step coil pattern of each phase; bit 0 is coil A, bit 3 coil D.
    function automatic logic [3:0] phase_coils(input logic [2:0] phase);
        logic [3:0] pattern;
        unique case (phase)
            3'd0: pattern = 4'h8;
            3'd1: pattern = 4'hC;
            3'd2: pattern = 4'h4;
            3'd3: pattern = 4'h6;
            3'd4: pattern = 4'h2;
            3'd5: pattern = 4'h3;
            3'd6: pattern = 4'h1;
            3'd7: pattern = 4'h9;
            default: pattern = 4'h0;
        endcase
        return pattern;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/half_step_stepper_sequencer.sv =====
// Top level of the half-step stepper sequencer: joins the motor state core
// and the two-entry result buffer. Depends on hss_pkg, hss_core, hss_outbuf.
//
// The block drives one four-coil unipolar stepper through eight half-step
// phases. A load transaction sets a signed count of pending steps; a tick
// transaction counts the hold-off down and, when stepping is allowed and steps
// are pending, drives the current phase's coil pattern and moves phase and
// position one step toward the count's sign. Every input transaction yields
// exactly one result transaction. Throughput is one transaction per clock
// while the buffer has room: the whole update is a single pass of logic
// from the state registers into the result buffer, where each result is
// registered before it reaches the output. The buffer holds two entries,
// so the input keeps accepting while one result waits; in_ready drops only
// when both entries are full. The step interval register is written through
// cfg_we and cfg_wdata and should be changed only while the block is idle.
`default_nettype none

module half_step_stepper_sequencer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [15:0]   cfg_wdata,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire hss_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output hss_pkg::out_t      out_data
);

    logic          fire;
    hss_pkg::out_t result;

    // A transaction is taken whenever the buffer has a free skid entry.
    assign fire = in_valid && in_ready;

    hss_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (in_data),
        .result    (result)
    );

    hss_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (result),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/hss_core.sv =====
// Motor state and the single-pass update for one input transaction.
// Depends on hss_pkg for the payload structs and the coil table.
`default_nettype none

module hss_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         fire,
    input  wire hss_pkg::in_t item,
    output hss_pkg::out_t     result
);

    logic [15:0]        interval_reg;
    logic [2:0]         phase_reg,   phase_next;
    logic signed [15:0] pend_reg,    pend_next;
    logic signed [31:0] pos_reg,     pos_next;
    logic               allowed_reg, allowed_next;
    logic [15:0]        hold_reg,    hold_next;
    logic [3:0]         coil_reg,    coil_next;

    logic [15:0] hold_dec;
    logic        stepped;

    assign hold_dec = hold_reg - 16'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        pend_next    = pend_reg;
        pos_next     = pos_reg;
        allowed_next = allowed_reg;
        hold_next    = hold_reg;
        coil_next    = coil_reg;
        stepped      = 1'b0;

        if (item.kind == hss_pkg::KIND_LOAD)
        begin
            pend_next = item.step_count;
        end
        else
        begin
            // Hold-off countdown comes first so a step may follow on expiry.
            if (hold_reg != 16'd0)
            begin
                hold_next = hold_dec;
                if (hold_dec == 16'd0)
                begin
                    if (pend_reg == 16'sd0)
                    begin
                        coil_next = 4'h0;
                    end
                    allowed_next = 1'b1;
                end
            end

            if (pend_reg != 16'sd0 && allowed_next)
            begin
                coil_next = hss_pkg::phase_coils(phase_reg);
                if (pend_reg[15])
                begin
                    phase_next = phase_reg - 3'd1;
                    pos_next   = pos_reg - 32'sd1;
                    pend_next  = pend_reg + 16'sd1;
                end
                else
                begin
                    phase_next = phase_reg + 3'd1;
                    pos_next   = pos_reg + 32'sd1;
                    pend_next  = pend_reg - 16'sd1;
                end
                // An interval of zero behaves as one tick.
                hold_next    = (interval_reg == 16'd0) ? 16'd1 : interval_reg;
                allowed_next = 1'b0;
                stepped      = 1'b1;
            end
        end

        result.coils     = coil_next;
        result.stepped   = stepped;
        result.position  = pos_next;
        result.remaining = pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= hss_pkg::INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            interval_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= 3'd0;
            pend_reg    <= 16'sd0;
            pos_reg     <= 32'sd0;
            allowed_reg <= 1'b1;
            hold_reg    <= 16'd0;
            coil_reg    <= 4'h0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            pend_reg    <= pend_next;
            pos_reg     <= pos_next;
            allowed_reg <= allowed_next;
            hold_reg    <= hold_next;
            coil_reg    <= coil_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hss_outbuf.sv =====
// Two-entry result buffer: an output register plus a skid register.
// Depends on hss_pkg for the result payload struct.
`default_nettype none

module hss_outbuf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire hss_pkg::out_t push_data,
    output logic               can_push,
    output logic               out_valid,
    input  wire logic          out_ready,
    output hss_pkg::out_t      out_data
);

    logic          main_valid_reg, main_valid_next;
    hss_pkg::out_t main_data_reg,  main_data_next;
    logic          skid_valid_reg, skid_valid_next;
    hss_pkg::out_t skid_data_reg,  skid_data_next;
    logic          pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            // No push can arrive while the skid entry is full.
            if (pop)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/hss_checker.sv =====
// Port-level checker for the half-step stepper sequencer and its bind.
// Depends on hss_pkg and on the ports of half_step_stepper_sequencer.
`default_nettype none

module hss_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_ready,
    input wire hss_pkg::in_t  in_data,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire hss_pkg::out_t out_data
);

    // A stalled result stays presented and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

    // With the output empty, the buffer must have room for a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input stalled while the output is empty");

    // A load into an empty output comes back next cycle with its count.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid && in_data.kind == hss_pkg::KIND_LOAD
        |=> out_valid && !out_data.stepped
            && out_data.remaining == $past(in_data.step_count))
    else $error("load result wrong");

    // A step always energizes at least one coil.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.stepped |-> out_data.coils != 4'h0)
    else $error("step with no coil driven");

endmodule

bind half_step_stepper_sequencer hss_checker u_hss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for half_step_stepper_sequencer: load and tick transactions
// go in, predicted coil drive, position and remaining steps are checked on the way out.
// Depends on hss_pkg and the sequencer RTL.

module testbench;

    // Generous bound: every transaction may see a full sender gap and a full
    // receiver stall, plus the long receiver hold-off and the phase pauses.
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD_CYCLES = 60;
    // Settling time after the last result came out.
    localparam int DRAIN_CYCLES = 4;
    // Half-step coil patterns of phases 0 to 7, phase 0 in the low nibble.
    localparam logic [31:0] COIL_SEQUENCE = 32'h9132_64C8;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic [15:0]   cfg_wdata = '0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    hss_pkg::in_t  in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    hss_pkg::out_t out_data;

    // Commands waiting to be offered, and drive states predicted for the
    // commands the block has already taken.
    hss_pkg::in_t  queued_commands[$];
    hss_pkg::out_t predicted_drive[$];

    // Our own copy of the motor state and of the step interval register.
    logic [2:0]         mot_phase = '0;
    logic signed [15:0] mot_pending = '0;
    logic signed [31:0] mot_position = '0;
    logic               mot_allowed = 1'b1;
    logic [15:0]        mot_holdoff = '0;
    logic [3:0]         mot_coils = '0;
    logic [15:0]        mot_interval = hss_pkg::INTERVAL_RESET;

    int error_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    bit idling_on = 1'b1;
    // The sequence asks for a long receiver hold-off by bumping the request
    // count; the receiver notices the difference and serves it.
    int hold_requests = 0;
    int hold_served = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    half_step_stepper_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Applies one accepted command to the motor state and returns the drive
    // state the block must report for it. A tick first runs the hold-off
    // countdown, then the step stage, so expiry and a step can share a tick.
    function automatic hss_pkg::out_t advance_motor(input hss_pkg::in_t cmd);
        hss_pkg::out_t result;
        logic          took_step;
        took_step = 1'b0;
        if (cmd.kind == hss_pkg::KIND_LOAD)
        begin
            // A load only replaces the pending count; a running hold-off stays.
            mot_pending = cmd.step_count;
        end
        else
        begin
            if (mot_holdoff != 16'd0)
            begin
                mot_holdoff = mot_holdoff - 16'd1;
                if (mot_holdoff == 16'd0)
                begin
                    // Expiry with nothing left to do releases the coils.
                    if (mot_pending == 16'sd0)
                        mot_coils = 4'h0;
                    mot_allowed = 1'b1;
                end
            end
            if (mot_pending != 16'sd0 && mot_allowed)
            begin
                mot_coils = COIL_SEQUENCE[{mot_phase, 2'b00} +: 4];
                if (mot_pending[15])
                begin
                    mot_phase = mot_phase - 3'd1;
                    mot_position = mot_position - 32'sd1;
                    mot_pending = mot_pending + 16'sd1;
                end
                else
                begin
                    mot_phase = mot_phase + 3'd1;
                    mot_position = mot_position + 32'sd1;
                    mot_pending = mot_pending - 16'sd1;
                end
                // An interval of zero behaves as one so the hold-off always ends.
                mot_holdoff = (mot_interval == 16'd0) ? 16'd1 : mot_interval;
                mot_allowed = 1'b0;
                took_step = 1'b1;
            end
        end
        result.coils = mot_coils;
        result.stepped = took_step;
        result.position = mot_position;
        result.remaining = mot_pending;
        return result;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic queue_command(input logic kind, input logic [15:0] count);
        hss_pkg::in_t cmd;
        cmd.kind = kind;
        cmd.step_count = count;
        queued_commands.push_back(cmd);
    endtask

    // Mostly ticks so that motion actually plays out, with loads of short
    // counts in both directions and now and then a full-range count. Ticks
    // carry random step_count bits, which the block must ignore.
    task automatic queue_random_commands(input int count, input int span);
        int draw;
        for (int i = 0; i < count; i++)
        begin
            draw = $urandom_range(0, 99);
            if (draw < 20)
                queue_command(hss_pkg::KIND_LOAD, 16'($urandom_range(0, 2 * span) - span));
            else if (draw < 25)
                queue_command(hss_pkg::KIND_LOAD, 16'($urandom));
            else
                queue_command(hss_pkg::KIND_TICK, 16'($urandom));
        end
    endtask

    // The register is written while cfg_we is held; the model follows at once
    // because the block is idle whenever this is called.
    task automatic write_interval(input logic [15:0] ticks);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= ticks;
        @(posedge clk);
        cfg_we <= 1'b0;
        mot_interval = ticks;
        @(negedge clk);
    endtask

    // Waits until every command went in and every predicted result came out.
    // Sampling on the falling edge keeps clear of the clocked processes.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (queued_commands.size() != 0 || in_valid || predicted_drive.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Sender: offers queued commands, predicts each one at the edge where it
    // is taken, and inserts random idle bursts between transactions.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predicted_drive.push_back(advance_motor(in_data));
            // A command still waiting for ready stays on the bus unchanged.
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (queued_commands.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (idling_on && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 11);
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_data <= queued_commands.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Receiver: checks each result transaction against the oldest prediction
    // and throttles out_ready with random stalls and the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        hss_pkg::out_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_drive.size() == 0)
                begin
                    report_mismatch("unexpected result position", out_data.position, '0);
                end
                else
                begin
                    want = predicted_drive.pop_front();
                    if (out_data.coils !== want.coils)
                        report_mismatch("coils", 32'(out_data.coils), 32'(want.coils));
                    if (out_data.stepped !== want.stepped)
                        report_mismatch("stepped", 32'(out_data.stepped), 32'(want.stepped));
                    if (out_data.position !== want.position)
                        report_mismatch("position", out_data.position, want.position);
                    if (out_data.remaining !== want.remaining)
                        report_mismatch("remaining", 32'(out_data.remaining),
                                        32'(want.remaining));
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                recv_gap = LONG_HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(0, 11);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin : watchdog
        int cycles_run;
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin : test_sequence
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset-value interval. An idle tick shows the de-energized reset
        // state, then one forward step starts an 80-tick hold-off. A load
        // during motion is blocked by that hold-off; a load of zero lets the
        // hold-off run out with nothing pending, which must release the coils.
        queue_command(hss_pkg::KIND_TICK, 16'h7FFF);
        queue_command(hss_pkg::KIND_LOAD, 16'd1);
        queue_command(hss_pkg::KIND_TICK, 16'h0000);
        queue_command(hss_pkg::KIND_LOAD, -16'sd3);
        queue_command(hss_pkg::KIND_TICK, 16'hFFFF);
        queue_command(hss_pkg::KIND_LOAD, 16'd0);
        for (int i = 0; i < 79; i++)
            queue_command(hss_pkg::KIND_TICK, i[0] ? 16'hAAAA : 16'h5555);
        wait_idle();

        // Zero interval acts as one, so every tick after a step expires the
        // hold-off and steps again on the same tick. The extreme counts run
        // both ways, and the reversal takes the position below zero.
        write_interval(16'd0);
        queue_command(hss_pkg::KIND_LOAD, 16'h7FFF);
        repeat (2) queue_command(hss_pkg::KIND_TICK, 16'h0000);
        queue_command(hss_pkg::KIND_LOAD, 16'h8000);
        repeat (5) queue_command(hss_pkg::KIND_TICK, 16'hFFFF);
        queue_command(hss_pkg::KIND_LOAD, 16'h0000);
        repeat (2) queue_command(hss_pkg::KIND_TICK, 16'h8000);
        queue_command(hss_pkg::KIND_LOAD, 16'hFFFF);
        repeat (2) queue_command(hss_pkg::KIND_TICK, 16'h0001);
        wait_idle();

        // Shortest real interval. Partway in the receiver holds off for a
        // long stretch while commands keep coming, so the result buffer fills
        // and the input stalls. Then the sender pauses until all is drained.
        write_interval(16'd1);
        queue_random_commands(150, 12);
        hold_requests++;
        wait_idle();
        queue_random_commands(150, 12);
        wait_idle();

        write_interval(16'($urandom_range(2, 9)));
        queue_random_commands(165, 20);
        wait_idle();

        // Closing stretch runs without idling on either side.
        idling_on = 1'b0;
        write_interval(16'($urandom_range(1, 4)));
        queue_random_commands(80, 10);
        wait_idle();

        // Longest interval last, since its hold-off cannot run out in time.
        write_interval(16'hFFFF);
        queue_command(hss_pkg::KIND_LOAD, -16'sd2);
        repeat (2) queue_command(hss_pkg::KIND_TICK, 16'h0000);
        queue_command(hss_pkg::KIND_LOAD, 16'd7);
        queue_command(hss_pkg::KIND_TICK, 16'hFFFF);
        wait_idle();

        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
